### src/acfp_pkg.sv
// Shared constants, types and helper functions of the ASCII command frame parser.
`timescale 1ns / 1ps

package acfp_pkg;

   // Default sizes and fixed port widths
   localparam int MAX_FIELDS_DEF = 8;
   localparam int TAG_CHARS_DEF  = 4;
   localparam int TABLE_SIZE     = 12;
   localparam int OUT_SLOTS      = 8;
   localparam int VALUE_W        = 16;
   localparam int COUNT_W        = 4;
   localparam int INDEX_W        = 4;
   localparam int ACC_W          = 17;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 136;
   localparam int RSP_USER_W     = 5;

   // Tag index codes
   localparam logic [INDEX_W-1:0] TAG_UNKNOWN   = 4'd12;
   localparam logic [INDEX_W-1:0] TAG_MATCH_LEN = 4'd4;

   // Character codes
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_VTAB    = 8'd11;
   localparam logic [7:0] CH_FF      = 8'd12;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_SEMI    = 8'd59;
   localparam logic [7:0] CH_LT      = 8'd60;
   localparam logic [7:0] CH_GT      = 8'd62;

   // Saturation limits of the decimal accumulator
   localparam logic [ACC_W-1:0]   ACC_SAT   = 17'd32768;
   localparam logic [ACC_W-1:0]   ACC_POS   = 17'd32767;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'h7FFF;

   // Command table, written in reading order (first character in the high byte)
   localparam logic [31:0] TAG_TABLE [TABLE_SIZE] = '{
      "UNDF", "RSND", "RREC", "SPWR", "RRST", "S_SF",
      "RREP", "RSSI", "ROLE", "GMSG", "CNTR", "SMCF"
   };

   // Control of the number field unit
   typedef struct packed {
      logic       restart;
      logic       feed;
      logic       stop;
      logic [7:0] chr;
   } num_ctrl_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   // Stored tags keep the first character in the low byte
   function automatic logic [31:0] swap_bytes(input logic [31:0] s);
      return {s[7:0], s[15:8], s[23:16], s[31:24]};
   endfunction

   function automatic logic [INDEX_W-1:0] tag_lookup(input logic [31:0] word);
      logic [INDEX_W-1:0] idx;
      idx = TAG_UNKNOWN;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (word == swap_bytes(TAG_TABLE[i])) begin
            idx = INDEX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### src/ascii_command_frame_parser_top.sv
// Top level of the ASCII command frame parser: line state, tag match and result register.
`timescale 1ns / 1ps
//
// Channel  | Direction | Ports                    | Contents
// ---------+-----------+--------------------------+------------------------------------
// req      | in        | req_tvalid/tready/tdata  | one received character per transaction
// rsp      | out       | rsp_tvalid/tready/tdata  | one parsed line per transaction
//          |           | rsp_tuser                | frame check and tag index
//
// One character is taken every cycle while req_tready is high; all per-character work (tag compare,
// multiply-by-ten accumulate) sits between the line state and the result register.
// A result appears in the cycle after its newline is accepted.
// req_tready drops only while a result waits and rsp_tready is low.
// Synchronous reset returns the block to the start of a line with no pending result.
//
module ascii_command_frame_parser_top
   import acfp_pkg::*;
#(
   parameter int MAX_FIELDS = MAX_FIELDS_DEF,
   parameter int TAG_CHARS  = TAG_CHARS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] value_count, [19:4] field_value_0,
                                              // ... [131:116] field_value_7, [135:132] zero
   output logic [RSP_USER_W-1:0] rsp_tuser    // [0] frame_ok, [4:1] tag_index
);

   localparam int SLOT_W = $clog2(MAX_FIELDS + 1);
   localparam int TLEN_W = $clog2(TAG_CHARS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TAG,
      PH_VALUES,
      PH_SKIP
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [8*TAG_CHARS-1:0]     tag_chars_ff, tag_chars_in;
   logic [TLEN_W-1:0]          tag_len_ff, tag_len_in;
   logic [7:0]                 first_ff, first_in;
   logic [7:0]                 last_ff, last_in;
   logic                       nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [VALUE_W-1:0]         store_ff [MAX_FIELDS];
   logic [VALUE_W-1:0]         store_in [MAX_FIELDS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]      rsp_user_ff, rsp_user_in;

   logic                       accept;
   logic [7:0]                 b;
   logic                       blank;
   logic                       is_nl;
   logic                       is_semi;
   logic [31:0]                tag_word;
   logic [INDEX_W-1:0]         tag_idx;
   logic                       opening;
   logic [SLOT_W-1:0]          slot_eff;
   logic                       close_wr;
   logic [SLOT_W-1:0]          close_idx;
   logic [VALUE_W-1:0]         close_val;
   logic                       emit;
   logic                       line_clear;
   num_ctrl_type               num_ctrl;
   logic [VALUE_W-1:0]         num_value;
   logic [VALUE_W-1:0]         slot_val [OUT_SLOTS];
   logic                       frame_ok;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign b          = req_tdata;
   assign blank      = is_blank(b);
   assign is_nl      = (b == CH_NEWLINE);
   assign is_semi    = (b == CH_SEMI);

   // Present the kept tag as a 32-bit word, first character in the low byte
   generate
      if (TAG_CHARS >= 4) begin : g_tag_wide
         assign tag_word = tag_chars_ff[31:0];
      end else begin : g_tag_narrow
         assign tag_word = 32'(tag_chars_ff);
      end
   endgenerate

   assign tag_idx = (4'(tag_len_ff) == TAG_MATCH_LEN) ? tag_lookup(tag_word) : TAG_UNKNOWN;

   // The first non-blank character of the value section opens field one
   assign opening  = (slot_ff == '0);
   assign slot_eff = opening ? SLOT_W'(1) : slot_ff;

   acfp_num_field u_num_field (
      .clock   (clock),
      .reset   (reset),
      .ctrl_i  (num_ctrl),
      .value_o (num_value)
   );

   // Next line state for the accepted character
   always_comb begin
      phase_in     = phase_ff;
      tag_chars_in = tag_chars_ff;
      tag_len_in   = tag_len_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      nonempty_in  = nonempty_ff;
      slot_in      = slot_ff;
      num_ctrl     = '{restart: 1'b0, feed: 1'b0, stop: 1'b0, chr: b};
      close_wr     = 1'b0;
      close_idx    = slot_eff - SLOT_W'(1);
      close_val    = opening ? '0 : num_value;
      emit         = 1'b0;
      line_clear   = 1'b0;

      if (accept) begin
         if (is_nl) begin
            emit       = nonempty_ff;
            line_clear = 1'b1;
         end else begin
            nonempty_in = 1'b1;
            if (!blank) begin
               last_in = b;
            end
            unique case (phase_ff)
               PH_IDLE: begin
                  if (!blank) begin
                     first_in = b;
                     phase_in = is_semi ? PH_SKIP : PH_TAG;
                  end
               end
               PH_TAG: begin
                  if (is_semi) begin
                     phase_in = (tag_idx != TAG_UNKNOWN) ? PH_VALUES : PH_SKIP;
                  end else if (tag_len_ff < TLEN_W'(TAG_CHARS)) begin
                     for (int k = 0; k < TAG_CHARS; k++) begin
                        if (tag_len_ff == TLEN_W'(k)) begin
                           tag_chars_in[8*k +: 8] = b;
                        end
                     end
                     tag_len_in = tag_len_ff + TLEN_W'(1);
                  end
               end
               PH_VALUES: begin
                  if (!opening || !blank) begin
                     if (is_semi) begin
                        // Close the field; open the next one unless the slots are full
                        close_wr = 1'b1;
                        if (slot_eff < SLOT_W'(MAX_FIELDS)) begin
                           slot_in          = slot_eff + SLOT_W'(1);
                           num_ctrl.restart = 1'b1;
                        end else begin
                           slot_in          = slot_eff;
                           num_ctrl.restart = opening;
                           num_ctrl.stop    = 1'b1;
                        end
                     end else begin
                        slot_in          = slot_eff;
                        num_ctrl.restart = opening;
                        num_ctrl.feed    = 1'b1;
                     end
                  end
               end
               PH_SKIP: begin
               end
               default: begin
               end
            endcase
         end
      end

      // Return to the start of a line after a newline
      if (line_clear) begin
         phase_in         = PH_IDLE;
         tag_chars_in     = '0;
         tag_len_in       = '0;
         first_in         = '0;
         last_in          = '0;
         nonempty_in      = 1'b0;
         slot_in          = '0;
         num_ctrl.restart = 1'b1;
      end
   end

   // Write closed fields into the value store
   always_comb begin
      for (int i = 0; i < MAX_FIELDS; i++) begin
         if (line_clear) begin
            store_in[i] = '0;
         end else if (close_wr && (close_idx == SLOT_W'(i))) begin
            store_in[i] = close_val;
         end else begin
            store_in[i] = store_ff[i];
         end
      end
   end

   // Values of the finished line; the open field is closed on the fly
   generate
      for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_slot
         if (g < MAX_FIELDS) begin : g_used
            always_comb begin
               if (SLOT_W'(g) < slot_ff) begin
                  if ((phase_ff == PH_VALUES) && (SLOT_W'(g) == slot_ff - SLOT_W'(1))) begin
                     slot_val[g] = num_value;
                  end else begin
                     slot_val[g] = store_ff[g];
                  end
               end else begin
                  slot_val[g] = '0;
               end
            end
         end else begin : g_unused
            assign slot_val[g] = '0;
         end
      end
   endgenerate

   assign frame_ok = (phase_ff != PH_IDLE) && (first_ff == CH_LT) && (last_ff == CH_GT);

   // Pack the result transaction
   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in[COUNT_W-1:0]   = COUNT_W'(slot_ff);
      for (int i = 0; i < OUT_SLOTS; i++) begin
         rsp_data_in[COUNT_W + VALUE_W*i +: VALUE_W] = slot_val[i];
      end
      rsp_user_in = {tag_idx, frame_ok};
   end

   // Hold a result until taken; load a new one on a non-empty newline
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tag_chars_ff <= '0;
         tag_len_ff   <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         nonempty_ff  <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FIELDS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         tag_chars_ff <= tag_chars_in;
         tag_len_ff   <= tag_len_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         nonempty_ff  <= nonempty_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_FIELDS; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### src/acfp_num_field.sv
// Decimal field accumulator: sign, digits and 16-bit saturation of one value field.
`timescale 1ns / 1ps

module acfp_num_field
   import acfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  num_ctrl_type       ctrl_i,
   output logic [VALUE_W-1:0] value_o
);

   logic [ACC_W-1:0] acc_ff, acc_in, acc_base;
   logic             neg_ff, neg_in, neg_base;
   logic             started_ff, started_in, started_base;
   logic             done_ff, done_in, done_base;
   logic [ACC_W+1:0] acc_next;
   logic [ACC_W-1:0] acc_neg;
   logic             is_digit;

   // Start from a fresh field when the field is reopened this cycle
   always_comb begin
      acc_base     = ctrl_i.restart ? '0 : acc_ff;
      neg_base     = ctrl_i.restart ? 1'b0 : neg_ff;
      started_base = ctrl_i.restart ? 1'b0 : started_ff;
      done_base    = ctrl_i.restart ? 1'b0 : done_ff;
   end

   // Multiply by ten and add the digit
   assign is_digit = (ctrl_i.chr >= CH_ZERO) && (ctrl_i.chr <= CH_NINE);
   assign acc_next = ({2'b00, acc_base} << 3) + ({2'b00, acc_base} << 1) +
                     (ACC_W + 2)'(ctrl_i.chr - CH_ZERO);

   // Advance the field: skip leading blanks, take one sign, then digits
   always_comb begin
      acc_in     = acc_base;
      neg_in     = neg_base;
      started_in = started_base;
      done_in    = done_base;
      if (ctrl_i.stop) begin
         done_in = 1'b1;
      end else if (ctrl_i.feed && !done_base) begin
         if (!started_base && ((ctrl_i.chr == CH_PLUS) || (ctrl_i.chr == CH_MINUS))) begin
            started_in = 1'b1;
            neg_in     = (ctrl_i.chr == CH_MINUS);
         end else if (is_digit) begin
            started_in = 1'b1;
            acc_in     = (acc_next > (ACC_W + 2)'(ACC_SAT)) ? ACC_SAT : acc_next[ACC_W-1:0];
         end else if (started_base || !is_blank(ctrl_i.chr)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         started_ff <= started_in;
         done_ff    <= done_in;
      end
   end

   // Saturated value of the field as it stands
   assign acc_neg = '0 - acc_ff;
   assign value_o = neg_ff ? acc_neg[VALUE_W-1:0] :
                    ((acc_ff > ACC_POS) ? VALUE_MAX : acc_ff[VALUE_W-1:0]);

endmodule

### src/acfp_checker.sv
// Port-level checker of the ASCII command frame parser and its bind to the top level.
`timescale 1ns / 1ps

module acfp_checker
   import acfp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // No result transaction is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A new result follows an accepted newline in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) |->
         $past(req_tvalid && req_tready && (req_tdata == CH_NEWLINE)))
      else $error("result without a newline");

   // Input is taken whenever no result waits
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // Values only for known tags, and never more than the slots
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= 4'd8) &&
         ((rsp_tdata[3:0] == 4'd0) || (rsp_tuser[4:1] != TAG_UNKNOWN)))
      else $error("value count inconsistent with tag");

endmodule

bind ascii_command_frame_parser_top acfp_checker u_acfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
